[rtl/mgcm_pkg.sv]
// Shared types and constants for the master gain, clip and peak meter block.
package mgcm_pkg;

    localparam int VOL_W  = 9;
    localparam int PAIR_W = 32;
    localparam int PEAK_W = 15;
    // Numerator of the gain reduction is volume * 2 * 32767, at most 25 bits.
    localparam int NUM_W  = VOL_W + 16;
    // The reduced gain quotient is always below twice the volume.
    localparam int QUO_W  = VOL_W + 1;

    localparam logic [PEAK_W-1:0] CLIP_LIMIT = 15'h7FFF;
    localparam logic [VOL_W-1:0]  UNITY_VOL  = 9'd256;

    typedef enum logic [2:0] {
        FUNC_SAMPLE      = 3'd0,
        FUNC_SET_VOL     = 3'd1,
        FUNC_BLOCK_START = 3'd2,
        FUNC_BLOCK_END   = 3'd3,
        FUNC_STOP        = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_DIV_L,
        ST_MUL_R,
        ST_DIV_R,
        ST_OP,
        ST_FINISH
    } state_t;

endpackage

[rtl/master_gain_clip_meter.sv]
// Master volume with peak meters and gain reduction on clip: control, state and result register.
// Control words pass through the operation state; a sample word runs the left and then the right
// channel through the multiplier, and through the divider when it clips with auto-reduce on.
// A new word is accepted only after the last result is loaded; the serial multiplier (one volume
// bit per cycle) and the serial divider (one quotient bit per cycle) are used in turn per channel.
// Reset (aresetn low, synchronous): volume 256, peaks 1, overall peak 0, clip flag and
// pair count 0, auto-reduce off, no result pending.
module master_gain_clip_meter #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_func,
    input  logic [SAMPLE_BITS-1:0] s_sample_left,
    input  logic [SAMPLE_BITS-1:0] s_sample_right,
    input  logic [7:0]             s_volume_value,
    input  logic                   s_meter_was_read,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_out_left,
    output logic [SAMPLE_BITS-1:0] m_out_right,
    output logic [SAMPLE_BITS-1:0] m_peak_left,
    output logic [SAMPLE_BITS-1:0] m_peak_right,
    output logic [14:0]            m_peak_overall,
    output logic                   m_clipped,
    output logic [8:0]             m_volume_now,
    output logic [31:0]            m_pairs_counted
);
    import mgcm_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + VOL_W;
    localparam logic [SB-1:0] CLIP_POS = {{(SB-PEAK_W){1'b0}}, CLIP_LIMIT};
    localparam logic [SB-1:0] CLIP_NEG = ~CLIP_POS + 1'b1;
    localparam logic [SB-1:0] ONE_SB   = {{(SB-1){1'b0}}, 1'b1};

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [SB-1:0]     sample_l_reg, sample_l_next;
    logic [SB-1:0]     sample_r_reg, sample_r_next;
    logic [7:0]        vol_val_reg, vol_val_next;
    logic              meter_read_reg, meter_read_next;
    logic [SB-1:0]     out_l_reg, out_l_next;
    logic [SB-1:0]     out_r_reg, out_r_next;

    logic              reduce_reg, reduce_next;
    logic [VOL_W-1:0]  volume_reg, volume_next;
    logic [SB-1:0]     peak_l_reg, peak_l_next;
    logic [SB-1:0]     peak_r_reg, peak_r_next;
    logic [PEAK_W-1:0] overall_reg, overall_next;
    logic              clip_reg, clip_next;
    logic [PAIR_W-1:0] count_reg, count_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_load;

    logic              mul_start, mul_done;
    logic [SB-1:0]     mul_a;
    logic [PW-1:0]     mul_prod;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num;
    logic [QUO_W-1:0]  div_quo;
    logic [QUO_W:0]    quo_inc;
    logic [VOL_W-1:0]  vol_reduced;

    logic [SB-1:0]     mul_src;
    logic [SB-1:0]     mag_cur;
    logic              neg_cur;
    logic [SB-1:0]     scaled_cur;
    logic              over_cur;
    logic [SB-1:0]     clamp_l, clamp_r;
    logic [PEAK_W-1:0] ov_l;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // Magnitude of the sample that feeds the multiplier; the left one comes
    // straight from the port in the accept cycle.
    assign mul_src = (state_reg == ST_IDLE) ? s_sample_left : sample_r_reg;
    assign mul_a   = mul_src[SB-1] ? (~mul_src + 1'b1) : mul_src;

    // Truncation toward zero of s*vol/256 is the floor of |s|*vol/256.
    assign mag_cur    = mul_prod[SB+7:8];
    assign neg_cur    = (state_reg == ST_MUL_L) ? sample_l_reg[SB-1] : sample_r_reg[SB-1];
    assign scaled_cur = neg_cur ? (~mag_cur + 1'b1) : mag_cur;
    assign over_cur   = mag_cur > CLIP_POS;

    // volume * 65534, built from shifts.
    assign div_num     = {volume_reg, 16'd0} - {{(NUM_W-VOL_W-1){1'b0}}, volume_reg, 1'b0};
    assign quo_inc     = {1'b0, div_quo} + 1'b1;
    assign vol_reduced = quo_inc[VOL_W:1];

    assign clamp_l = (peak_l_reg > CLIP_POS) ? CLIP_POS :
                     ((peak_l_reg == '0) ? ONE_SB : peak_l_reg);
    assign clamp_r = (peak_r_reg > CLIP_POS) ? CLIP_POS :
                     ((peak_r_reg == '0) ? ONE_SB : peak_r_reg);
    assign ov_l    = (clamp_l[PEAK_W-1:0] > overall_reg) ? clamp_l[PEAK_W-1:0] : overall_reg;

    assign m_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        sample_l_next   = sample_l_reg;
        sample_r_next   = sample_r_reg;
        vol_val_next    = vol_val_reg;
        meter_read_next = meter_read_reg;
        out_l_next      = out_l_reg;
        out_r_next      = out_r_reg;
        reduce_next     = reduce_reg;
        volume_next     = volume_reg;
        peak_l_next     = peak_l_reg;
        peak_r_next     = peak_r_reg;
        overall_next    = overall_reg;
        clip_next       = clip_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mul_start       = 1'b0;
        div_start       = 1'b0;

        if (cfg_valid) begin
            reduce_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next       = func_t'(s_func);
                    sample_l_next   = s_sample_left;
                    sample_r_next   = s_sample_right;
                    vol_val_next    = s_volume_value;
                    meter_read_next = s_meter_was_read;
                    out_l_next      = '0;
                    out_r_next      = '0;
                    if (func_t'(s_func) == FUNC_SAMPLE) begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL_L;
                    end else begin
                        state_next = ST_OP;
                    end
                end
            end
            ST_MUL_L: begin
                if (mul_done) begin
                    if (mag_cur > peak_l_reg) begin
                        peak_l_next = mag_cur;
                    end
                    if (reduce_reg && over_cur) begin
                        out_l_next = neg_cur ? CLIP_NEG : CLIP_POS;
                        div_start  = 1'b1;
                        state_next = ST_DIV_L;
                    end else begin
                        out_l_next = scaled_cur;
                        mul_start  = 1'b1;
                        state_next = ST_MUL_R;
                    end
                end
            end
            ST_DIV_L: begin
                if (div_done) begin
                    // The right channel already runs at the reduced volume.
                    volume_next = vol_reduced;
                    mul_start   = 1'b1;
                    state_next  = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                if (mul_done) begin
                    if (mag_cur > peak_r_reg) begin
                        peak_r_next = mag_cur;
                    end
                    if (reduce_reg && over_cur) begin
                        out_r_next = neg_cur ? CLIP_NEG : CLIP_POS;
                        div_start  = 1'b1;
                        state_next = ST_DIV_R;
                    end else begin
                        out_r_next = scaled_cur;
                        count_next = count_reg + 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_R: begin
                if (div_done) begin
                    volume_next = vol_reduced;
                    count_next  = count_reg + 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_OP: begin
                case (func_reg)
                    FUNC_SET_VOL: begin
                        volume_next = {1'b0, vol_val_reg};
                    end
                    FUNC_BLOCK_START: begin
                        if (meter_read_reg) begin
                            peak_l_next = {1'b0, peak_l_reg[SB-1:1]};
                            peak_r_next = {1'b0, peak_r_reg[SB-1:1]};
                        end
                    end
                    FUNC_BLOCK_END: begin
                        peak_l_next  = clamp_l;
                        peak_r_next  = clamp_r;
                        if ((peak_l_reg > CLIP_POS) || (peak_r_reg > CLIP_POS)) begin
                            clip_next = 1'b1;
                        end
                        overall_next = (clamp_r[PEAK_W-1:0] > ov_l) ?
                                       clamp_r[PEAK_W-1:0] : ov_l;
                    end
                    FUNC_STOP: begin
                        clip_next  = 1'b0;
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (m_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            reduce_reg  <= 1'b0;
            volume_reg  <= UNITY_VOL;
            peak_l_reg  <= ONE_SB;
            peak_r_reg  <= ONE_SB;
            overall_reg <= '0;
            clip_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            reduce_reg  <= reduce_next;
            volume_reg  <= volume_next;
            peak_l_reg  <= peak_l_next;
            peak_r_reg  <= peak_r_next;
            overall_reg <= overall_next;
            clip_reg    <= clip_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        sample_l_reg   <= sample_l_next;
        sample_r_reg   <= sample_r_next;
        vol_val_reg    <= vol_val_next;
        meter_read_reg <= meter_read_next;
        out_l_reg      <= out_l_next;
        out_r_reg      <= out_r_next;
        if (m_load) begin
            m_out_left      <= out_l_reg;
            m_out_right     <= out_r_reg;
            m_peak_left     <= peak_l_reg;
            m_peak_right    <= peak_r_reg;
            m_peak_overall  <= overall_reg;
            m_clipped       <= clip_reg;
            m_volume_now    <= volume_reg;
            m_pairs_counted <= count_reg;
        end
    end

    assign m_valid = m_valid_reg;

    mgcm_mul #(
        .SAMPLE_BITS(SB)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (volume_next),
        .done    (mul_done),
        .product (mul_prod)
    );

    mgcm_div #(
        .SAMPLE_BITS(SB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (mag_cur),
        .done     (div_done),
        .quotient (div_quo)
    );

`ifndef SYNTHESIS
    // The volume never rises above unity; reduction never raises the gain above the value it started from.
    a_volume_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        volume_reg <= UNITY_VOL)
        else $error("volume above unity");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (peak_l_reg <= {1'b1, {(SB-1){1'b0}}}) && (peak_r_reg <= {1'b1, {(SB-1){1'b0}}}))
        else $error("channel peak beyond the largest scaled magnitude");

    a_overall_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> overall_reg >= $past(overall_reg))
        else $error("overall peak decreased");

    a_div_only_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (reduce_reg && over_cur))
        else $error("gain reduction started without a clipping sample");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");
`endif

endmodule

[rtl/mgcm_mul.sv]
// Bit-serial shift-and-add multiplier: sample magnitude times volume, one volume bit per cycle.
module mgcm_mul #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [SAMPLE_BITS-1:0]                mcand,
    input  logic [mgcm_pkg::VOL_W-1:0]            mplier,
    output logic                                  done,
    output logic [SAMPLE_BITS+mgcm_pkg::VOL_W-1:0] product
);
    import mgcm_pkg::*;

    localparam int PW    = SAMPLE_BITS + VOL_W;
    localparam int CNT_W = $clog2(VOL_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]    acc_reg, acc_next;
    logic [PW-1:0]    mcand_reg, mcand_next;
    logic [VOL_W-1:0] mplier_reg, mplier_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CNT_W'(VOL_W);
            acc_next    = '0;
            mcand_next  = {{VOL_W{1'b0}}, mcand};
            mplier_next = mplier;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[PW-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[VOL_W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/mgcm_div.sv]
// Restoring divider for the gain reduction, one quotient bit per cycle.
module mgcm_div #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mgcm_pkg::NUM_W-1:0] num,
    input  logic [SAMPLE_BITS-1:0]     den,
    output logic                       done,
    output logic [mgcm_pkg::QUO_W-1:0] quotient
);
    import mgcm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SB-1:0]    rem_reg, rem_next;
    logic [SB-1:0]    den_reg, den_next;
    logic [QUO_W-1:0] nbits_reg, nbits_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [SB:0]      trial;
    logic [SB:0]      diff;
    logic             fits;

    // The quotient is known to fit in QUO_W bits, so the upper numerator
    // bits start out as a partial remainder that is already below den.
    assign trial = {rem_reg, nbits_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        nbits_next = nbits_reg;
        quo_next   = quo_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(QUO_W);
            rem_next   = {{(SB-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
            den_next   = den;
            nbits_next = num[QUO_W-1:0];
            quo_next   = '0;
        end else if (busy_reg) begin
            rem_next   = fits ? diff[SB-1:0] : trial[SB-1:0];
            nbits_next = {nbits_reg[QUO_W-2:0], 1'b0};
            quo_next   = {quo_reg[QUO_W-2:0], fits};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        nbits_reg <= nbits_next;
        quo_reg   <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the master gain, clip and peak meter block.
module tb_top;
    import mgcm_pkg::*;

    localparam int SB = 20;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [2:0]    func;
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic [7:0]    vol;
        logic          mwr;
    } stereo_word_t;

    typedef struct packed {
        logic [SB-1:0]     out_left;
        logic [SB-1:0]     out_right;
        logic [SB-1:0]     peak_left;
        logic [SB-1:0]     peak_right;
        logic [PEAK_W-1:0] peak_overall;
        logic              clipped;
        logic [VOL_W-1:0]  volume_now;
        logic [PAIR_W-1:0] pairs_counted;
    } meter_word_t;

    typedef struct packed {
        logic [SB-1:0] out;
        logic [SB-1:0] peak;
    } chan_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_func = '0;
    logic [SB-1:0] s_sample_left = '0;
    logic [SB-1:0] s_sample_right = '0;
    logic [7:0] s_volume_value = '0;
    logic s_meter_was_read = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SB-1:0] m_out_left;
    logic [SB-1:0] m_out_right;
    logic [SB-1:0] m_peak_left;
    logic [SB-1:0] m_peak_right;
    logic [14:0] m_peak_overall;
    logic m_clipped;
    logic [8:0] m_volume_now;
    logic [31:0] m_pairs_counted;

    // Shadow of the block's state, updated as words are accepted.
    logic              reduce_mode = 1'b0;
    logic [VOL_W-1:0]  gain = UNITY_VOL;
    logic [SB-1:0]     peak_l = SB'(1);
    logic [SB-1:0]     peak_r = SB'(1);
    logic [PEAK_W-1:0] peak_max = '0;
    logic              clip_seen = 1'b0;
    logic [PAIR_W-1:0] pair_total = '0;

    stereo_word_t words_to_send[$];
    meter_word_t  meter_words_due[$];
    stereo_word_t word_in_flight;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int last_gen_vol = 255;
    int unsigned cycle_count = 0;

    master_gain_clip_meter #(.SAMPLE_BITS(SB)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_sample_left   (s_sample_left),
        .s_sample_right  (s_sample_right),
        .s_volume_value  (s_volume_value),
        .s_meter_was_read(s_meter_was_read),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_peak_left     (m_peak_left),
        .m_peak_right    (m_peak_right),
        .m_peak_overall  (m_peak_overall),
        .m_clipped       (m_clipped),
        .m_volume_now    (m_volume_now),
        .m_pairs_counted (m_pairs_counted)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Scales one channel and updates the gain when reduce mode clips it.
    function automatic chan_t scale_channel(input logic signed [SB-1:0] smp,
                                            input logic [SB-1:0] peak_in);
        longint scaled, mag, lim;
        chan_t r;
        scaled = (longint'(smp) * longint'(gain)) / 256;
        mag = (scaled < 0) ? -scaled : scaled;
        r.peak = (mag > longint'(peak_in)) ? mag[SB-1:0] : peak_in;
        r.out = scaled[SB-1:0];
        if (reduce_mode && mag > longint'(CLIP_LIMIT)) begin
            gain = VOL_W'(((longint'(gain) * longint'(CLIP_LIMIT) * 2) / mag + 1) / 2);
            lim = (scaled < 0) ? -longint'(CLIP_LIMIT) : longint'(CLIP_LIMIT);
            r.out = lim[SB-1:0];
        end
        return r;
    endfunction

    function automatic logic [SB-1:0] clamp_peak(input logic [SB-1:0] p);
        if (p > SB'(CLIP_LIMIT)) begin
            clip_seen = 1'b1;
            return SB'(CLIP_LIMIT);
        end
        return (p == '0) ? SB'(1) : p;
    endfunction

    function automatic meter_word_t apply_gain_meter(input stereo_word_t w);
        meter_word_t r;
        chan_t cl, cr;
        r.out_left = '0;
        r.out_right = '0;
        case (w.func)
            FUNC_SAMPLE: begin
                cl = scale_channel(w.left, peak_l);
                peak_l = cl.peak;
                cr = scale_channel(w.right, peak_r);
                peak_r = cr.peak;
                r.out_left = cl.out;
                r.out_right = cr.out;
                pair_total = pair_total + 1'b1;
            end
            FUNC_SET_VOL: gain = {1'b0, w.vol};
            FUNC_BLOCK_START: begin
                if (w.mwr) begin
                    peak_l = peak_l >> 1;
                    peak_r = peak_r >> 1;
                end
            end
            FUNC_BLOCK_END: begin
                peak_l = clamp_peak(peak_l);
                peak_r = clamp_peak(peak_r);
                if (peak_l > SB'(peak_max)) peak_max = peak_l[PEAK_W-1:0];
                if (peak_r > SB'(peak_max)) peak_max = peak_r[PEAK_W-1:0];
            end
            FUNC_STOP: begin
                clip_seen = 1'b0;
                pair_total = '0;
            end
            default: begin
            end
        endcase
        r.peak_left = peak_l;
        r.peak_right = peak_r;
        r.peak_overall = peak_max;
        r.clipped = clip_seen;
        r.volume_now = gain;
        r.pairs_counted = pair_total;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                meter_words_due.push_back(apply_gain_meter(word_in_flight));
            if (!s_valid || s_ready) begin
                if (words_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    word_in_flight = words_to_send[0];
                    words_to_send.delete(0);
                    s_valid <= 1'b1;
                    s_func <= word_in_flight.func;
                    s_sample_left <= word_in_flight.left;
                    s_sample_right <= word_in_flight.right;
                    s_volume_value <= word_in_flight.vol;
                    s_meter_was_read <= word_in_flight.mwr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        meter_word_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_out_left, m_out_right, m_peak_left, m_peak_right,
                        m_peak_overall, m_clipped, m_volume_now, m_pairs_counted};
                if (meter_words_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: out %h/%h peak %h/%h",
                                 got.out_left, got.out_right, got.peak_left, got.peak_right);
                end else begin
                    want = meter_words_due[0];
                    meter_words_due.delete(0);
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch, expected out %h/%h peak %h/%h ovr %h clip %b",
                                     want.out_left, want.out_right, want.peak_left,
                                     want.peak_right, want.peak_overall, want.clipped);
                            $display("  expected vol %h pairs %h",
                                     want.volume_now, want.pairs_counted);
                            $display("  actual out %h/%h peak %h/%h ovr %h clip %b",
                                     got.out_left, got.out_right, got.peak_left,
                                     got.peak_right, got.peak_overall, got.clipped);
                            $display("  actual vol %h pairs %h",
                                     got.volume_now, got.pairs_counted);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_item(input logic [2:0] f, input logic [SB-1:0] l,
                             input logic [SB-1:0] r, input logic [7:0] v, input logic m);
        words_to_send.push_back('{f, l, r, v, m});
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (words_to_send.size() != 0 || s_valid || meter_words_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reduce(input logic v);
        wait_drained();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reduce_mode = v;
        @(negedge aclk);
    endtask

    // Mixes quiet samples, full-scale samples and samples that land near the
    // clip threshold for the most recently programmed volume.
    function automatic logic [SB-1:0] pick_sample();
        int mag, kind;
        kind = $urandom_range(0, 99);
        if (kind < 25)
            return SB'($urandom);
        if (kind < 50)
            mag = $urandom_range(0, 2000);
        else if (kind < 80)
            mag = int'(CLIP_LIMIT) * 256 / ((last_gen_vol == 0) ? 1 : last_gen_vol)
                  + $urandom_range(0, 6) - 3;
        else
            mag = $urandom_range(0, 40000);
        if (mag > 524287) mag = 524287;
        if (mag < 0) mag = 0;
        return $urandom_range(0, 1) ? SB'(-mag) : SB'(mag);
    endfunction

    function automatic logic [7:0] pick_volume();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 20) return 8'd255;
        if (kind < 30) return 8'd0;
        return 8'($urandom);
    endfunction

    // Mostly well-formed meter blocks with random content, plus control words
    // and stray words that break the block structure.
    task automatic gen_random(input int n);
        int made, roll, k;
        logic [7:0] v;
        logic [2:0] f;
        made = 0;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                v = pick_volume();
                last_gen_vol = v;
                push_item(FUNC_SET_VOL, SB'($urandom), SB'($urandom), v, 1'($urandom));
                made++;
            end else if (roll < 30) begin
                push_item(FUNC_STOP, SB'($urandom), SB'($urandom), 8'($urandom), 1'($urandom));
                made++;
            end else if (roll < 33) begin
                f = 3'(FUNC_STOP) + 3'($urandom_range(1, 3));
                push_item(f, SB'($urandom), SB'($urandom), 8'($urandom), 1'($urandom));
            end
            if (roll >= 88) begin
                f = 3'($urandom);
                push_item(f, pick_sample(), pick_sample(), 8'($urandom), 1'($urandom));
                if (f <= 3'(FUNC_STOP)) made++;
            end else begin
                push_item(FUNC_BLOCK_START, SB'($urandom), SB'($urandom), 8'($urandom),
                          1'($urandom));
                k = $urandom_range(1, 10);
                repeat (k) push_item(FUNC_SAMPLE, pick_sample(), pick_sample(),
                                     8'($urandom), 1'($urandom));
                push_item(FUNC_BLOCK_END, SB'($urandom), SB'($urandom), 8'($urandom),
                          1'($urandom));
                made += k + 2;
            end
        end
    endtask

    initial begin
        int src_pct[6], sink_pct[6];
        logic red_cfg[6];
        src_pct = '{0, 45, 0, 25, 45, 25};
        sink_pct = '{0, 0, 45, 25, 0, 25};
        red_cfg = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Unity volume only exists right after reset, so the exact clip
        // boundary is exercised first with reduce mode on.
        write_reduce(1'b1);
        push_item(FUNC_BLOCK_START, '0, '0, 8'($urandom), 1'b1);
        push_item(FUNC_BLOCK_END, '0, '0, 8'($urandom), 1'b0);
        push_item(FUNC_SAMPLE, SB'(32767), SB'(-32767), '0, 1'b0);
        push_item(FUNC_SAMPLE, SB'(32768), SB'(-32768), '0, 1'b1);
        push_item(FUNC_SAMPLE, SB'(524287), SB'(-524288), 8'hFF, 1'b0);
        push_item(FUNC_BLOCK_END, '0, '0, 8'($urandom), 1'b0);
        push_item(FUNC_BLOCK_START, '0, '0, 8'($urandom), 1'b0);
        push_item(FUNC_BLOCK_START, '0, '0, 8'($urandom), 1'b1);
        push_item(FUNC_SAMPLE, '0, SB'(-1), '0, 1'b0);

        write_reduce(1'b0);
        push_item(FUNC_SET_VOL, '0, '0, 8'd255, 1'b0);
        push_item(FUNC_SAMPLE, SB'(524287), SB'(-524288), '0, 1'b0);
        push_item(FUNC_SAMPLE, SB'(-524288), SB'(524287), '0, 1'b1);
        push_item(FUNC_SET_VOL, SB'(-1), SB'(-1), 8'd0, 1'b1);
        push_item(FUNC_SAMPLE, SB'(-1), SB'(524287), '0, 1'b0);
        push_item(FUNC_SET_VOL, '0, '0, 8'd128, 1'b0);
        // Negative products truncate toward zero.
        push_item(FUNC_SAMPLE, SB'(-3), SB'(3), '0, 1'b0);
        push_item(FUNC_BLOCK_END, '0, '0, 8'($urandom), 1'b0);
        push_item(FUNC_STOP, '0, '0, 8'($urandom), 1'b1);
        push_item(3'(FUNC_STOP) + 3'd1, SB'(-1), SB'(-1), 8'hFF, 1'b1);
        push_item(3'(FUNC_STOP) + 3'd2, '0, '0, 8'h00, 1'b0);
        push_item(3'(FUNC_STOP) + 3'd3, SB'($urandom), SB'($urandom), 8'($urandom), 1'b1);
        push_item(FUNC_BLOCK_START, '0, '0, 8'($urandom), 1'b1);
        push_item(FUNC_BLOCK_END, '0, '0, 8'($urandom), 1'b0);
        last_gen_vol = 128;

        for (int p = 0; p < 6; p++) begin
            write_reduce(red_cfg[p]);
            src_idle_pct = src_pct[p];
            sink_stall_pct = sink_pct[p];
            gen_random(150);
            // The test waits until every queued word is sent and every outstanding result is back.
            wait_drained();
            gen_random(150);
        end

        wait_drained();
        repeat (60) @(negedge aclk);
        if (fail_count == 0 && meter_words_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
